/* rtl/core/dtm_pkg.sv */
// dtm_pkg: shared types and constants for the 3x3 terrain metrics block.
// Field widths, register map and reset values. No dependencies.
package dtm_pkg;

    localparam int ELEV_W    = 16;   // elevation sample width, signed
    localparam int ROW_W     = 16;
    localparam int COL_OUT_W = 12;
    localparam int NCOLS_W   = 13;
    localparam int EN_W      = 3;
    localparam int RUG_W     = 19;
    localparam int POS_W     = 20;
    localparam int ROUGH_W   = 16;

    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam int DEF_MAX_COLS = 4096;

    localparam logic [NCOLS_W-1:0] NUM_COLS_RST = 13'd4096;
    localparam logic [ROW_W-1:0]   NUM_ROWS_RST = 16'hFFFF;
    localparam logic [EN_W-1:0]    METRIC_EN_RST = 3'b111;

    // metric_enable bit positions
    localparam int EN_RUG   = 0;
    localparam int EN_POS   = 1;
    localparam int EN_ROUGH = 2;

    typedef logic signed [ELEV_W-1:0] t_elev;

    // register index, byte address = 4 * index
    typedef enum logic [1:0] {
        REG_NUM_COLS  = 2'd0,
        REG_NUM_ROWS  = 2'd1,
        REG_METRIC_EN = 2'd2
    } t_reg_idx;

endpackage

/* rtl/core/dtm_ram.sv */
// dtm_ram: generic simple dual-port RAM, one write and one registered read port.
// Standalone, no package dependencies.
module dtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dem_3x3_terrain_metrics.sv */
// dem_3x3_terrain_metrics: 3x3 ruggedness / position / roughness over an elevation stream.
// Depends on dtm_pkg and dtm_ram (line buffer storage).
//
// Usage: elevation samples enter in row-major order on the input channel
// (i_in_valid / o_in_stall); i_first_sample marks cell (0,0) of a new grid.
// Results leave on the output channel (o_out_valid / i_out_stall); a transfer
// happens when valid is high and stall is low. Grid width, height and the
// metric enable mask are set over the APB port while the block is idle.
// The first num_cols + 1 samples of a grid give no result; after that each sample gives
// the metrics of the cell up one row, left one column (column 0: last column two rows up).
// A sample's result passes the stage 1 and window registers before the output register.
// Throughput: one sample per cycle while no stall holds the pipeline, set by the single
// registered read of the shared line buffer RAM (both previous lines in one word).
// Pipeline: line buffer read -> window register -> metrics/result register.
// Each stage moves when the stage after it is empty or moving, so input is
// still taken while a result waits, until all three stages are full.
// Reset clears counters, window and valid flags; the line buffer RAM is not
// cleared and needs no clearing pass.
module dem_3x3_terrain_metrics #(
    parameter int MAX_COLS = dtm_pkg::DEF_MAX_COLS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [dtm_pkg::ELEV_W-1:0]   i_elevation,
    input  logic                                i_first_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dtm_pkg::ROW_W-1:0]           o_center_row,
    output logic [dtm_pkg::COL_OUT_W-1:0]       o_center_col,
    output logic                                o_is_border,
    output logic [dtm_pkg::RUG_W-1:0]           o_ruggedness_x8,
    output logic signed [dtm_pkg::POS_W-1:0]    o_position_x8,
    output logic [dtm_pkg::ROUGH_W-1:0]         o_roughness,
    output logic                                o_frame_end,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dtm_pkg::APB_AW-1:0]          paddr,
    input  logic [dtm_pkg::APB_DW-1:0]          pwdata,
    output logic [dtm_pkg::APB_DW-1:0]          prdata,
    output logic                                pready
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int NW = (CW + 1 > dtm_pkg::NCOLS_W) ? CW + 1 : dtm_pkg::NCOLS_W;
    localparam int EW = dtm_pkg::ELEV_W;
    localparam int RW = dtm_pkg::ROW_W;

    // ---------------- configuration ----------------
    logic [dtm_pkg::NCOLS_W-1:0] r_num_cols;
    logic [RW-1:0]               r_num_rows;
    logic [dtm_pkg::EN_W-1:0]    r_metric_en;
    logic                        cfg_wr;
    dtm_pkg::t_reg_idx           cfg_idx;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = dtm_pkg::t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols  <= dtm_pkg::NUM_COLS_RST;
            r_num_rows  <= dtm_pkg::NUM_ROWS_RST;
            r_metric_en <= dtm_pkg::METRIC_EN_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                dtm_pkg::REG_NUM_COLS:  r_num_cols  <= pwdata[dtm_pkg::NCOLS_W-1:0];
                dtm_pkg::REG_NUM_ROWS:  r_num_rows  <= pwdata[RW-1:0];
                dtm_pkg::REG_METRIC_EN: r_metric_en <= pwdata[dtm_pkg::EN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            dtm_pkg::REG_NUM_COLS:  prdata = dtm_pkg::APB_DW'(r_num_cols);
            dtm_pkg::REG_NUM_ROWS:  prdata = dtm_pkg::APB_DW'(r_num_rows);
            dtm_pkg::REG_METRIC_EN: prdata = dtm_pkg::APB_DW'(r_metric_en);
            default:                prdata = '0;
        endcase
    end

    // effective grid size (clamped)
    logic [NW-1:0] num_cols_x;
    logic [NW-1:0] ncol;
    logic [RW-1:0] nrow;

    assign num_cols_x = NW'(r_num_cols);

    always_comb begin
        if (num_cols_x < NW'(3)) begin
            ncol = NW'(3);
        end else if (num_cols_x > NW'(MAX_COLS)) begin
            ncol = NW'(MAX_COLS);
        end else begin
            ncol = num_cols_x;
        end
        nrow = (r_num_rows < RW'(3)) ? RW'(3) : r_num_rows;
    end

    // ---------------- stage enables ----------------
    logic r_v1, r_v2, r_ov;
    logic en_out, en2, en1, in_acc;

    assign en_out     = !r_ov || !i_out_stall;
    assign en2        = !r_v2 || en_out;
    assign en1        = !r_v1 || en2;
    assign in_acc     = i_in_valid && en1;
    assign o_in_stall = !en1;

    // ---------------- stage 0: position counters ----------------
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [NW-1:0] s0_col;
    logic [RW-1:0] s0_row;
    logic [NW-1:0] n_col;
    logic [RW-1:0] n_row;

    always_comb begin
        s0_col = i_first_sample ? '0 : NW'(r_col);
        s0_row = i_first_sample ? '0 : r_row;
        // counter left past the width by a register change
        if (s0_col >= ncol) begin
            s0_col = '0;
            s0_row = s0_row + RW'(1);
        end
        if (s0_row >= nrow) begin
            s0_row = '0;
        end
        n_col = s0_col + NW'(1);
        n_row = s0_row;
        if (n_col >= ncol) begin
            n_col = '0;
            n_row = s0_row + RW'(1);
            if (n_row >= nrow) begin
                n_row = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            r_col <= n_col[CW-1:0];
            r_row <= n_row;
        end
    end

    // ---------------- line buffers ----------------
    // one word per column: {line above, line two above}
    logic [2*EW-1:0]    ram_q;
    logic [2*EW-1:0]    ram_wdata;
    logic               ram_we;
    dtm_pkg::t_elev     r_e1;
    logic [CW-1:0]      r_c1;
    logic [RW-1:0]      r_r1;
    logic               r_byp1;
    dtm_pkg::t_elev     r_byp_a1;
    dtm_pkg::t_elev     r_byp_b1;
    dtm_pkg::t_elev     w_top;
    dtm_pkg::t_elev     w_mid;
    logic               byp;

    dtm_ram #(
        .WIDTH (2 * EW),
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_c1),
        .i_wdata (ram_wdata),
        .i_re    (en1),
        .i_raddr (s0_col[CW-1:0]),
        .o_rdata (ram_q)
    );

    // write by the item leaving stage 1 hits the address read this cycle
    // only after a restart at column 0; forward it
    assign byp       = r_v1 && (s0_col[CW-1:0] == r_c1);
    assign w_top     = r_byp1 ? r_byp_b1 : dtm_pkg::t_elev'(ram_q[EW-1:0]);
    assign w_mid     = r_byp1 ? r_byp_a1 : dtm_pkg::t_elev'(ram_q[2*EW-1:EW]);
    assign ram_we    = r_v1 && en2;
    assign ram_wdata = {r_e1, w_mid};

    // ---------------- stage 1 ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_e1     <= i_elevation;
            r_c1     <= s0_col[CW-1:0];
            r_r1     <= s0_row;
            r_byp1   <= byp;
            r_byp_a1 <= r_e1;
            r_byp_b1 <= w_mid;
        end
    end

    logic [NW-1:0] c1x;
    logic          s1_prod;
    logic          s1_fend;
    logic          s1_border;
    logic [RW-1:0] s1_cr;
    logic [NW-1:0] s1_cc;

    always_comb begin
        c1x     = NW'(r_c1);
        s1_prod = (r_r1 >= RW'(2)) || ((r_r1 == RW'(1)) && (r_c1 != '0));
        s1_fend = (r_r1 == nrow - RW'(1)) && (c1x == ncol - NW'(1));
        if (r_c1 != '0) begin
            s1_cr = r_r1 - RW'(1);
            s1_cc = c1x - NW'(1);
        end else begin
            // center wraps to the last column two rows up
            s1_cr = r_r1 - RW'(2);
            s1_cc = ncol - NW'(1);
        end
        s1_border = (s1_cr == '0) || (s1_cc == '0) || (s1_cc == ncol - NW'(1)) ||
                    (s1_cr == nrow - RW'(1));
    end

    // two previous window columns: [0..2] oldest, [3..5] newer; top, middle, bottom
    dtm_pkg::t_elev r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (ram_we) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= w_top;
            r_win[4] <= w_mid;
            r_win[5] <= r_e1;
        end
    end

    // ---------------- stage 2: window register ----------------
    dtm_pkg::t_elev r_w2 [9];
    logic [RW-1:0]  r_cr2;
    logic [NW-1:0]  r_cc2;
    logic           r_bord2;
    logic           r_fend2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1 && s1_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int k = 0; k < 6; k++) begin
                r_w2[k] <= r_win[k];
            end
            r_w2[6] <= w_top;
            r_w2[7] <= w_mid;
            r_w2[8] <= r_e1;
            r_cr2   <= s1_cr;
            r_cc2   <= s1_cc;
            r_bord2 <= s1_border;
            r_fend2 <= s1_fend;
        end
    end

    // ---------------- metrics ----------------
    dtm_pkg::t_elev                   centre;
    dtm_pkg::t_elev                   mx;
    dtm_pkg::t_elev                   mn;
    logic signed [EW:0]               dif;
    logic [EW:0]                      adif;
    logic [dtm_pkg::RUG_W-1:0]        rug;
    logic signed [dtm_pkg::RUG_W-1:0] nsum;
    logic signed [dtm_pkg::POS_W-1:0] pos;
    logic [dtm_pkg::ROUGH_W-1:0]      rough;
    logic [dtm_pkg::RUG_W-1:0]        rug_o;
    logic signed [dtm_pkg::POS_W-1:0] pos_o;
    logic [dtm_pkg::ROUGH_W-1:0]      rough_o;

    always_comb begin
        centre = r_w2[4];
        mx     = r_w2[0];
        mn     = r_w2[0];
        rug    = '0;
        nsum   = '0;
        dif    = '0;
        adif   = '0;
        for (int k = 0; k < 9; k++) begin
            if (r_w2[k] > mx) begin
                mx = r_w2[k];
            end
            if (r_w2[k] < mn) begin
                mn = r_w2[k];
            end
            if (k != 4) begin
                dif  = {r_w2[k][EW-1], r_w2[k]} - {centre[EW-1], centre};
                adif = dif[EW] ? (EW+1)'(-dif) : (EW+1)'(dif);
                rug  = rug + dtm_pkg::RUG_W'(adif);
                nsum = nsum + {{(dtm_pkg::RUG_W-EW){r_w2[k][EW-1]}}, r_w2[k]};
            end
        end
        pos   = {centre[EW-1], centre, 3'b000} - {nsum[dtm_pkg::RUG_W-1], nsum};
        // range fits in 16 bits, so the wrapped difference is exact
        rough = dtm_pkg::ROUGH_W'(mx - mn);

        rug_o   = (r_bord2 || !r_metric_en[dtm_pkg::EN_RUG])   ? '0 : rug;
        pos_o   = (r_bord2 || !r_metric_en[dtm_pkg::EN_POS])   ? '0 : pos;
        rough_o = (r_bord2 || !r_metric_en[dtm_pkg::EN_ROUGH]) ? '0 : rough;
    end

    // ---------------- result register ----------------
    logic [RW-1:0]                    r_o_row;
    logic [dtm_pkg::COL_OUT_W-1:0]    r_o_col;
    logic                             r_o_bord;
    logic [dtm_pkg::RUG_W-1:0]        r_o_rug;
    logic signed [dtm_pkg::POS_W-1:0] r_o_pos;
    logic [dtm_pkg::ROUGH_W-1:0]      r_o_rough;
    logic                             r_o_fend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_out) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_o_row   <= r_cr2;
            r_o_col   <= r_cc2[dtm_pkg::COL_OUT_W-1:0];
            r_o_bord  <= r_bord2;
            r_o_rug   <= rug_o;
            r_o_pos   <= pos_o;
            r_o_rough <= rough_o;
            r_o_fend  <= r_fend2;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_center_row    = r_o_row;
    assign o_center_col    = r_o_col;
    assign o_is_border     = r_o_bord;
    assign o_ruggedness_x8 = r_o_rug;
    assign o_position_x8   = r_o_pos;
    assign o_roughness     = r_o_rough;
    assign o_frame_end     = r_o_fend;

    // ---------------- assertions ----------------
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_border) |->
            (o_ruggedness_x8 == '0) && (o_position_x8 == '0) && (o_roughness == '0))
        else $error("border cell with nonzero metric");

    a_first_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_first_sample) |=> r_v1 && (r_c1 == '0) && (r_r1 == '0))
        else $error("first sample did not restart position at (0,0)");

    a_fend_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> !o_is_border)
        else $error("frame end on a border cell");

endmodule

/* test/dtm_checker.sv */
// dtm_checker: watches the sample, result and APB ports of dem_3x3_terrain_metrics,
// predicts the metrics of every cell and compares each result transfer field by field.
// Depends on dtm_pkg; hands the mismatch count and the number of open results to tb_top.
module dtm_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [dtm_pkg::ELEV_W-1:0]   i_elevation,
    input  logic                                i_first_sample,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [dtm_pkg::ROW_W-1:0]           i_center_row,
    input  logic [dtm_pkg::COL_OUT_W-1:0]       i_center_col,
    input  logic                                i_is_border,
    input  logic [dtm_pkg::RUG_W-1:0]           i_ruggedness_x8,
    input  logic signed [dtm_pkg::POS_W-1:0]    i_position_x8,
    input  logic [dtm_pkg::ROUGH_W-1:0]         i_roughness,
    input  logic                                i_frame_end,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [dtm_pkg::APB_AW-1:0]          i_paddr,
    input  logic [dtm_pkg::APB_DW-1:0]          i_pwdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS   = dtm_pkg::DEF_MAX_COLS;
    localparam int PRINT_CAP  = 100;

    typedef struct packed {
        logic [dtm_pkg::ROW_W-1:0]     row;
        logic [dtm_pkg::COL_OUT_W-1:0] col;
        logic                          border;
        logic [dtm_pkg::RUG_W-1:0]     rug;
        logic [dtm_pkg::POS_W-1:0]     pos;
        logic [dtm_pkg::ROUGH_W-1:0]   rough;
        logic                          fend;
    } t_cell_metrics;

    logic [dtm_pkg::NCOLS_W-1:0] cfg_cols;
    logic [dtm_pkg::ROW_W-1:0]   cfg_rows;
    logic [dtm_pkg::EN_W-1:0]    cfg_en;

    int line_up  [MAX_COLS];
    int line_up2 [MAX_COLS];
    int win [6];   // two previous window columns: top, middle, bottom each
    int col_pos;
    int row_pos;

    t_cell_metrics cell_q [$];
    t_cell_metrics want;

    task automatic report_error(input string msg);
        if (o_fail_count < PRINT_CAP) begin
            $display("%t mismatch: %s", $realtime, msg);
        end
        o_fail_count++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v) begin
            report_error($sformatf("cell (%0d,%0d) %s: want %0h got %0h",
                                   want.row, want.col, name, want_v, got_v));
        end
    endtask

    task automatic predict_cell(input int elev, input logic restart);
        int ncol, nrow, c, r, cr, cc, mid, hi, lo, sum, rugs, d, k;
        int w [9];
        logic has_result, on_rim;
        t_cell_metrics m;
        ncol = cfg_cols;
        if (ncol < 3) ncol = 3;
        if (ncol > MAX_COLS) ncol = MAX_COLS;
        nrow = (cfg_rows < 3) ? 3 : cfg_rows;
        c = col_pos;
        r = row_pos;
        if (restart) begin
            c = 0;
            r = 0;
        end
        // counters left outside the grid by a register change
        if (c >= ncol) begin
            c = 0;
            r++;
        end
        if (r >= nrow) r = 0;

        for (k = 0; k < 6; k++) w[k] = win[k];
        w[6] = line_up2[c];
        w[7] = line_up[c];
        w[8] = elev;

        has_result = (r >= 2) || (r == 1 && c >= 1);
        if (has_result) begin
            if (c >= 1) begin
                cr = r - 1;
                cc = c - 1;
            end else begin
                // column 0 describes the last cell of the row two up
                cr = r - 2;
                cc = ncol - 1;
            end
            on_rim = (cr == 0) || (cc == 0) || (cc == ncol - 1) || (cr == nrow - 1);
            m = '0;
            m.row    = cr[dtm_pkg::ROW_W-1:0];
            m.col    = cc[dtm_pkg::COL_OUT_W-1:0];
            m.border = on_rim;
            m.fend   = (r == nrow - 1) && (c == ncol - 1);
            if (!on_rim) begin
                mid  = w[4];
                hi   = w[0];
                lo   = w[0];
                sum  = 0;
                rugs = 0;
                for (k = 0; k < 9; k++) begin
                    if (w[k] > hi) hi = w[k];
                    if (w[k] < lo) lo = w[k];
                    if (k != 4) begin
                        d = w[k] - mid;
                        rugs += (d < 0) ? -d : d;
                        sum += w[k];
                    end
                end
                if (cfg_en[dtm_pkg::EN_RUG]) m.rug = rugs[dtm_pkg::RUG_W-1:0];
                if (cfg_en[dtm_pkg::EN_POS]) begin
                    d = 8 * mid - sum;
                    m.pos = d[dtm_pkg::POS_W-1:0];
                end
                if (cfg_en[dtm_pkg::EN_ROUGH]) begin
                    d = hi - lo;
                    m.rough = d[dtm_pkg::ROUGH_W-1:0];
                end
            end
            cell_q.push_back(m);
        end

        line_up2[c] = line_up[c];
        line_up[c]  = elev;
        for (k = 0; k < 3; k++) win[k] = win[k + 3];
        win[3] = w[6];
        win[4] = w[7];
        win[5] = w[8];

        c++;
        if (c >= ncol) begin
            c = 0;
            r++;
            if (r >= nrow) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_cols = dtm_pkg::NUM_COLS_RST;
            cfg_rows = dtm_pkg::NUM_ROWS_RST;
            cfg_en   = dtm_pkg::METRIC_EN_RST;
            for (int k = 0; k < MAX_COLS; k++) begin
                line_up[k]  = 0;
                line_up2[k] = 0;
            end
            for (int k = 0; k < 6; k++) win[k] = 0;
            col_pos = 0;
            row_pos = 0;
            cell_q.delete();
            o_fail_count = 0;
        end else begin
            // results first: a result can never come from this edge's sample
            if (i_out_valid && !i_out_stall) begin
                if (cell_q.size() == 0) begin
                    report_error($sformatf("unexpected result for cell (%0d,%0d)",
                                           i_center_row, i_center_col));
                end else begin
                    want = cell_q.pop_front();
                    compare_field("center_row", want.row, i_center_row);
                    compare_field("center_col", want.col, i_center_col);
                    compare_field("is_border", want.border, i_is_border);
                    compare_field("ruggedness_x8", want.rug, i_ruggedness_x8);
                    compare_field("position_x8", want.pos, {i_position_x8});
                    compare_field("roughness", want.rough, i_roughness);
                    compare_field("frame_end", want.fend, i_frame_end);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_cell(i_elevation, i_first_sample);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (dtm_pkg::t_reg_idx'(i_paddr[3:2]))
                    dtm_pkg::REG_NUM_COLS:  cfg_cols = i_pwdata[dtm_pkg::NCOLS_W-1:0];
                    dtm_pkg::REG_NUM_ROWS:  cfg_rows = i_pwdata[dtm_pkg::ROW_W-1:0];
                    dtm_pkg::REG_METRIC_EN: cfg_en   = i_pwdata[dtm_pkg::EN_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending <= cell_q.size();
    end

endmodule

/* test/tb_top.sv */
// tb_top: stimulus and verdict for dem_3x3_terrain_metrics.
// Drives elevation grids and APB register writes with random gaps and stalls;
// dtm_checker (dtm_checker.sv) does all prediction and comparison. Needs dtm_pkg.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 940;
    localparam int WIDE_ITEMS   = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int RUN_LIMIT    = 600000;
    localparam int WIDE_COLS    = 4096;

    typedef enum int {HT_NOISE, HT_SLOPE, HT_CLIFF} t_height_style;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    dtm_pkg::t_elev i_elevation = '0;
    logic i_first_sample = 1'b0;
    logic i_out_stall = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [dtm_pkg::APB_AW-1:0] paddr = '0;
    logic [dtm_pkg::APB_DW-1:0] pwdata = '0;

    logic                             o_in_stall;
    logic                             o_out_valid;
    logic [dtm_pkg::ROW_W-1:0]        o_center_row;
    logic [dtm_pkg::COL_OUT_W-1:0]    o_center_col;
    logic                             o_is_border;
    logic [dtm_pkg::RUG_W-1:0]        o_ruggedness_x8;
    logic signed [dtm_pkg::POS_W-1:0] o_position_x8;
    logic [dtm_pkg::ROUGH_W-1:0]      o_roughness;
    logic                             o_frame_end;
    logic [dtm_pkg::APB_DW-1:0]       prdata;
    logic                             pready;

    int fail_count;
    int pending;

    logic no_gaps = 1'b1;   // both sides run without idling while set
    int   hold_req = 0;
    int   hold_taken = 0;
    int   hold_left = 0;
    int   cycle_count = 0;
    int   n_random = 0;
    int   level = 0;
    int   cols_now = WIDE_COLS;

    dem_3x3_terrain_metrics dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_elevation     (i_elevation),
        .i_first_sample  (i_first_sample),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_center_row    (o_center_row),
        .o_center_col    (o_center_col),
        .o_is_border     (o_is_border),
        .o_ruggedness_x8 (o_ruggedness_x8),
        .o_position_x8   (o_position_x8),
        .o_roughness     (o_roughness),
        .o_frame_end     (o_frame_end),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    dtm_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_elevation     (i_elevation),
        .i_first_sample  (i_first_sample),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_center_row    (o_center_row),
        .i_center_col    (o_center_col),
        .i_is_border     (o_is_border),
        .i_ruggedness_x8 (o_ruggedness_x8),
        .i_position_x8   (o_position_x8),
        .i_roughness     (o_roughness),
        .i_frame_end     (o_frame_end),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_taken != hold_req) begin
            hold_taken  <= hold_taken + 1;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !no_gaps && ($urandom_range(0, 99) < 34);
        end
    end

    function automatic int cols_in_use(input int v);
        if (v < 3) return 3;
        if (v > WIDE_COLS) return WIDE_COLS;
        return v;
    endfunction

    task automatic offer_sample(input dtm_pkg::t_elev e, input logic first);
        while (!no_gaps && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_elevation    <= e;
        i_first_sample <= first;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // lower valid, wait for every open result, then let the pipeline empty
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input dtm_pkg::t_reg_idx idx,
                             input logic [dtm_pkg::APB_DW-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx == dtm_pkg::REG_NUM_COLS) begin
            cols_now = cols_in_use(int'(data[dtm_pkg::NCOLS_W-1:0]));
        end
    endtask

    task automatic stream_grid(input int count, input logic restart,
                               input t_height_style style, input logic random_part);
        int k;
        dtm_pkg::t_elev e;
        logic first;
        for (k = 0; k < count; k++) begin
            first = (k == 0) ? restart : (random_part && $urandom_range(0, 199) == 0);
            case (style)
                HT_NOISE: e = dtm_pkg::t_elev'($urandom_range(0, 65535));
                HT_SLOPE: begin
                    level = level + int'($urandom_range(0, 200)) - 100;
                    if (level > 32767) level = 32767;
                    if (level < -32768) level = -32768;
                    e = dtm_pkg::t_elev'(level);
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: e = 16'sh7FFF;
                        1: e = 16'sh8000;
                        default: e = dtm_pkg::t_elev'($urandom_range(0, 65535));
                    endcase
                end
            endcase
            offer_sample(e, first);
            if (random_part) begin
                n_random++;
                if (n_random == 250 || n_random == 750) hold_req <= hold_req + 1;
                if (n_random == 500) drain_results();
            end
        end
    endtask

    initial begin
        int k, j, pick, new_cols, new_rows, rows_eff, n_grids, cells, cap, count;
        logic grow, restart;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset-value registers: full-width grid, no result within the first row
        stream_grid(WIDE_ITEMS, 1'b1, HT_SLOPE, 1'b0);
        drain_results();

        // widths and heights below 3 act as 3: one interior cell per grid
        write_reg(dtm_pkg::REG_NUM_COLS, 2);
        write_reg(dtm_pkg::REG_NUM_ROWS, 2);
        write_reg(dtm_pkg::REG_METRIC_EN, 7);
        for (k = 0; k < 9; k++) offer_sample((k == 4) ? 16'sh7FFF : 16'sh8000, k == 0);
        // second grid starts from the automatic wrap after frame end
        for (k = 0; k < 9; k++) offer_sample((k == 4) ? 16'sh8000 : 16'sh7FFF, 1'b0);
        drain_results();
        write_reg(dtm_pkg::REG_METRIC_EN, 0);
        stream_grid(9, 1'b0, HT_NOISE, 1'b0);
        drain_results();

        // shrink the width mid-grid: column counter lands outside the grid
        write_reg(dtm_pkg::REG_NUM_COLS, 20);
        write_reg(dtm_pkg::REG_NUM_ROWS, 1000);
        write_reg(dtm_pkg::REG_METRIC_EN, 5);
        stream_grid(55, 1'b1, HT_SLOPE, 1'b0);
        drain_results();
        write_reg(dtm_pkg::REG_NUM_COLS, 10);
        stream_grid(40, 1'b0, HT_SLOPE, 1'b0);
        drain_results();

        // shrink the height mid-grid: row counter wraps to 0
        stream_grid(63, 1'b1, HT_NOISE, 1'b0);
        drain_results();
        write_reg(dtm_pkg::REG_NUM_ROWS, 4);
        stream_grid(50, 1'b0, HT_NOISE, 1'b0);
        drain_results();

        // width beyond the line buffers acts as the maximum; height 0 acts as 3
        write_reg(dtm_pkg::REG_NUM_COLS, 8191);
        write_reg(dtm_pkg::REG_NUM_ROWS, 0);
        write_reg(dtm_pkg::REG_METRIC_EN, 3);
        stream_grid(WIDE_ITEMS, 1'b1, HT_SLOPE, 1'b0);
        no_gaps <= 1'b0;

        rows_eff = 3;
        while (n_random < RANDOM_ITEMS) begin
            drain_results();
            grow = 1'b0;
            if (n_random == 0 || $urandom_range(0, 9) < 7) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) new_cols = $urandom_range(0, 2);
                else if (pick == 1) new_cols = $urandom_range(25, 200);
                else new_cols = $urandom_range(3, 24);
                grow = cols_in_use(new_cols) > cols_now;
                write_reg(dtm_pkg::REG_NUM_COLS, new_cols);
            end
            if ($urandom_range(0, 9) < 7) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) new_rows = $urandom_range(0, 2);
                else if (pick == 1) new_rows = $urandom_range(60000, 65535);
                else new_rows = $urandom_range(3, 8);
                rows_eff = (new_rows < 3) ? 3 : new_rows;
                write_reg(dtm_pkg::REG_NUM_ROWS, new_rows);
            end
            write_reg(dtm_pkg::REG_METRIC_EN, $urandom_range(0, 7));

            n_grids = $urandom_range(1, 3);
            for (j = 0; j < n_grids; j++) begin
                cells = cols_now * rows_eff;
                cap   = 3 * cols_now + $urandom_range(0, 200);
                count = (cells < cap) ? cells : cap;
                // now and then a grid is cut short
                if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count);
                if (count > RANDOM_ITEMS - n_random) count = RANDOM_ITEMS - n_random;
                restart = (j == 0 && grow) ? 1'b1 : ($urandom_range(0, 3) != 0);
                stream_grid(count, restart, t_height_style'($urandom_range(0, 2)), 1'b1);
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
